// ===== hdl/scbc_pkg.sv =====
// shared types and constants for the size class block cache
package scbc_pkg;

  localparam int SIZE_W   = 32;
  localparam int HANDLE_W = 32;
  localparam int ROUND_W  = 34;
  localparam int CLASS_W  = 3;
  localparam int BLK_W    = 6;
  localparam int MB_W     = 12;
  localparam int CFG_W    = 12;
  localparam int MB_SHIFT = 20;

  localparam logic [BLK_W-1:0] BLK_RESET = 6'd63;
  localparam logic [MB_W-1:0]  MB_RESET  = 12'd4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_MAX_BLOCKS    = 1'b0,
    CFG_MAX_MEGABYTES = 1'b1
  } cfg_index_t;

endpackage

// ===== hdl/scbc_class_map.sv =====
// size to class mapping and size rounding for allocate and free requests
module scbc_class_map import scbc_pkg::*; #(
  parameter int MIN_CLASS_BITS = 10,
  parameter int NUM_CLASSES    = 8,
  parameter int ALIGN_BITS     = 12,
  parameter int CLS_W          = 3
) (
  input  logic               command,
  input  logic [SIZE_W-1:0]  request_size,
  output logic [CLS_W-1:0]   cls,
  output logic               valid,
  output logic [ROUND_W-1:0] rounded
);

  localparam logic [ROUND_W-1:0] MIN_SIZE = ROUND_W'(1) << MIN_CLASS_BITS;
  localparam logic [ROUND_W-1:0] MAX_SIZE = MIN_SIZE << (NUM_CLASSES - 1);

  logic [ROUND_W-1:0] size_w;
  logic [ROUND_W-1:0] size_dec;
  logic [ROUND_W-1:0] ceil_vec;
  logic [ROUND_W-1:0] floor_vec;
  logic [CLS_W-1:0]   ceil_cls;
  logic [CLS_W-1:0]   floor_cls;

  assign size_w    = ROUND_W'(request_size);
  assign size_dec  = size_w - ROUND_W'(1);
  assign ceil_vec  = size_dec >> MIN_CLASS_BITS;
  assign floor_vec = size_w >> MIN_CLASS_BITS;

  // ceiling class: bit length of (size-1) above the minimum class
  always_comb begin
    ceil_cls = '0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (ceil_vec[i]) ceil_cls = CLS_W'(i + 1);
    end
  end

  // floor class: leading one of size above the minimum class
  always_comb begin
    floor_cls = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (floor_vec[i]) floor_cls = CLS_W'(i);
    end
  end

  always_comb begin
    cls     = '0;
    valid   = 1'b0;
    rounded = size_w;
    if (command == CMD_ALLOC) begin
      if (size_w <= MIN_SIZE) begin
        rounded = MIN_SIZE;
        valid   = 1'b1;
      end else if (size_w > MAX_SIZE) begin
        // oversize is rounded down to the alignment, then grows by one alignment unit
        rounded = ((size_w >> ALIGN_BITS) + ROUND_W'(1)) << ALIGN_BITS;
      end else begin
        cls     = ceil_cls;
        rounded = MIN_SIZE << ceil_cls;
        valid   = 1'b1;
      end
    end else begin
      if (size_w >= MIN_SIZE && size_w <= MAX_SIZE) begin
        cls     = floor_cls;
        rounded = MIN_SIZE << floor_cls;
        valid   = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/scbc_stack_mem.sv =====
// single port handle stack memory with registered read data
module scbc_stack_mem import scbc_pkg::*; #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [HANDLE_W-1:0] wdata,
  output logic [HANDLE_W-1:0] rdata
);

  logic [HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/size_class_block_cache_top.sv =====
// top level of the size class block cache
//
// A request (command, request_size, block_handle) is taken at a clock edge
// where start is high and busy is low. busy stays low: one request can be
// taken every cycle. An allocate request pops a cached handle from the
// stack of its rounded class or reports a miss; a free request pushes the
// handle onto the stack of its floor class unless the class is over its
// block or megabyte limit or its stack is full.
// Each request gives exactly one result, shown with done high for one
// cycle: the request is registered, then the class decode, count update and
// stack memory access run, and the result is registered. The handle stack
// is a single port memory, one access per request, so the read of a pop and
// the write of a push share the same cycle slot. The receiver cannot stall:
// results must be taken when done is high. The user must write limits on
// the cfg channel (cfg_ready is always high) only while no request is in
// flight; the block does not enforce this. Reset clears all class counts,
// so every stack starts empty; limits return to 63 blocks and 4 megabytes.
module size_class_block_cache_top import scbc_pkg::*; #(
  parameter int MIN_CLASS_BITS = 10,
  parameter int NUM_CLASSES    = 8,
  parameter int ALIGN_BITS     = 12,
  parameter int STACK_DEPTH    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [SIZE_W-1:0]   request_size,
  input  logic [HANDLE_W-1:0] block_handle,
  output logic                done,
  output logic [ROUND_W-1:0]  rounded_size,
  output logic [CLASS_W-1:0]  size_class,
  output logic                class_valid,
  output logic                from_cache,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                kept,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int DEPTH   = NUM_CLASSES * STACK_DEPTH;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int BYTES_W = CNT_W + MIN_CLASS_BITS + NUM_CLASSES + MB_W;
  localparam int CMP_W   = CNT_W + BLK_W;

  // limits
  logic [BLK_W-1:0] max_blocks;
  logic [MB_W-1:0]  max_mb;

  // request register
  logic                in_vld;
  logic                in_cmd;
  logic [SIZE_W-1:0]   in_size;
  logic [HANDLE_W-1:0] in_handle;

  // class counts
  logic [CNT_W-1:0] count [NUM_CLASSES];

  logic [CLS_W-1:0]   cls;
  logic               cls_valid;
  logic [ROUND_W-1:0] rounded;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_dec;
  logic [BYTES_W-1:0] bytes;
  logic               over_limit;
  logic               pop;
  logic               push;
  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  addr;
  logic [HANDLE_W-1:0] rd_data;
  logic [CLS_W+CLASS_W-1:0] cls_ext;

  // result register
  logic [ROUND_W-1:0] r_rounded;
  logic [CLASS_W-1:0] r_cls;
  logic               r_valid;
  logic               r_hit;
  logic               r_kept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks <= BLK_RESET;
      max_mb     <= MB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_BLOCKS:    max_blocks <= cfg_data[BLK_W-1:0];
        CFG_MAX_MEGABYTES: max_mb     <= cfg_data[MB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd    <= command;
      in_size   <= request_size;
      in_handle <= block_handle;
    end
  end

  scbc_class_map #(
    .MIN_CLASS_BITS (MIN_CLASS_BITS),
    .NUM_CLASSES    (NUM_CLASSES),
    .ALIGN_BITS     (ALIGN_BITS),
    .CLS_W          (CLS_W)
  ) u_class_map (
    .command      (in_cmd),
    .request_size (in_size),
    .cls          (cls),
    .valid        (cls_valid),
    .rounded      (rounded)
  );

  assign n     = count[cls];
  assign n_dec = n - CNT_W'(1);

  // cached bytes of the class: count times block size, as a shift
  assign bytes = BYTES_W'(n) << (MIN_CLASS_BITS + int'(cls));

  assign over_limit = (CMP_W'(n) > CMP_W'(max_blocks))
                   || ((bytes >> MB_SHIFT) > BYTES_W'(max_mb))
                   || (n >= CNT_W'(STACK_DEPTH));

  assign pop  = in_vld && (in_cmd == CMD_ALLOC) && cls_valid && (n != '0);
  assign push = in_vld && (in_cmd == CMD_FREE) && cls_valid && !over_limit;

  // push writes at the top, pop reads the entry below it
  assign idx  = push ? n[IDX_W-1:0] : n_dec[IDX_W-1:0];
  assign addr = ADDR_W'(cls) * ADDR_W'(STACK_DEPTH) + ADDR_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        count[i] <= '0;
      end
    end else if (pop) begin
      count[cls] <= n_dec;
    end else if (push) begin
      count[cls] <= n + CNT_W'(1);
    end
  end

  scbc_stack_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack_mem (
    .clk   (clk),
    .we    (push),
    .addr  (addr),
    .wdata (in_handle),
    .rdata (rd_data)
  );

  assign cls_ext = {{CLASS_W{1'b0}}, cls};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    r_rounded <= rounded;
    r_cls     <= cls_ext[CLASS_W-1:0];
    r_valid   <= cls_valid;
    r_hit     <= pop;
    r_kept    <= push;
  end

  assign rounded_size = r_rounded;
  assign size_class   = r_cls;
  assign class_valid  = r_valid;
  assign from_cache   = r_hit;
  assign kept         = r_kept;
  assign handle_out   = r_hit ? rd_data : '0;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_vld |=> done)
    else $error("request in flight gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_vld |-> (n <= CNT_W'(STACK_DEPTH)))
    else $error("class count beyond stack depth");

  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(from_cache && kept))
    else $error("result both popped and pushed");

  a_invalid_no_stack: assert property (@(posedge clk) disable iff (rst)
    (done && !class_valid) |-> (!from_cache && !kept && size_class == '0))
    else $error("stack touched for a size outside the classes");

  a_pop_drops_count: assert property (@(posedge clk) disable iff (rst)
    pop |=> (count[$past(cls)] == $past(n_dec)))
    else $error("pop did not lower the class count");

endmodule
